// ===== src/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Shared types and constants: request and response payloads, status and
// operation codes, and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DataWidth  = 32;
  // Encoded entries need two extra bits to hold twice a value minus the minimum.
  localparam int EntryWidth = DataWidth + 2;
  localparam int CountWidth = 8;
  localparam int CapWidth   = 8;
  localparam logic [CapWidth-1:0] CapReset = 8'd128;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic signed [DataWidth-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                     status;
    logic signed [DataWidth-1:0] popped_value;
    logic signed [DataWidth-1:0] top_value;
    logic signed [DataWidth-1:0] min_value;
    logic [CountWidth-1:0]       entry_count;
    logic                        is_empty;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic load_top;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic refill;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack
// A stack of signed 32-bit words that reports its running minimum with every
// result. Requests arrive on the in channel (push a value or pop), results
// leave on the out channel; both use valid and stall. The capacity register
// is written through cfg_we_i and cfg_wdata_i; the user must write it only
// while no request is in flight, as the block does not enforce this. One
// request is processed at a time: execute, a top refill for a pop that
// leaves entries (the new top entry is read back through the registered
// read port of the entry memory), then the output hand-off. The next request
// is taken the cycle after the result is registered, so none is taken before
// the last is done. Results wait in an output register while the receiver
// stalls; a second result waits inside until that register frees. Reset
// empties the stack, clears the minimum and sets the capacity to 128.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
  parameter int DEPTH = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mts_pkg::CapWidth-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mts_pkg::req_t                in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mts_pkg::rsp_t                out_rsp_o
);

  // Commands and status between the sequencer and the datapath.
  mts_pkg::dp_cmd_t    dp_cmd;
  mts_pkg::dp_status_t dp_status;

  // The controller opens the input only when idle and steps each request
  // through execute, an optional top refill, and the output hand-off.
  mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // The datapath keeps the encoded top entry in a register so that a push
  // or a pop works on it directly, with the memory holding every entry.
  mts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .ctrl_i      (dp_cmd),
    .status_o    (dp_status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== src/mts_mem.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack entry memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mts_mem #(
  parameter int DEPTH = 128
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [$clog2(DEPTH)-1:0]                waddr_i,
  input  logic signed [mts_pkg::EntryWidth-1:0]   wdata_i,
  input  logic                                    re_i,
  input  logic [$clog2(DEPTH)-1:0]                raddr_i,
  output logic signed [mts_pkg::EntryWidth-1:0]   rdata_o
);

  logic [mts_pkg::EntryWidth-1:0] mem_q [DEPTH];
  logic [mts_pkg::EntryWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mts_dp.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack datapath
// Holds the count, the running minimum, the encoded top entry, the capacity
// register and the output register, and drives the entry memory.
// ----------------------------------------------------------------------------
module mts_dp #(
  parameter int DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mts_pkg::CapWidth-1:0]         cfg_wdata_i,
  input  mts_pkg::req_t                        in_req_i,
  input  mts_pkg::dp_cmd_t                     ctrl_i,
  output mts_pkg::dp_status_t                  status_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output mts_pkg::rsp_t                        out_rsp_o
);

  localparam int DW = mts_pkg::DataWidth;
  localparam int EW = mts_pkg::EntryWidth;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > mts_pkg::CountWidth) ? CW : mts_pkg::CountWidth;

  logic [mts_pkg::CapWidth-1:0] cap_q;
  mts_pkg::req_t                req_q;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic signed [DW-1:0]         min_q, min_d;
  logic signed [EW-1:0]         top_enc_q;
  logic signed [DW-1:0]         popped_q;
  mts_pkg::status_e             st_q;
  logic                         out_valid_q;
  mts_pkg::rsp_t                rsp_q, rsp_d;

  logic [XW-1:0]        cnt_x, cap_x, depth_x, limit;
  logic                 full, empty, is_push, push_low, top_low, cnt_ge2;
  logic signed [DW-1:0] v, top_dec;
  logic signed [EW-1:0] v_x, min_x, twice_v, twice_min, enc_push, restore;
  logic [CW-1:0]        cnt_m2;
  logic                 mem_we, mem_re;
  logic signed [EW-1:0] mem_rdata;

  // Effective capacity is the register limited to the memory depth.
  assign cnt_x   = XW'(cnt_q);
  assign cap_x   = XW'(cap_q);
  assign depth_x = XW'(DEPTH);
  assign limit   = (cap_x < depth_x) ? cap_x : depth_x;
  assign full    = (cnt_x >= limit);
  assign empty   = (cnt_q == '0);
  assign is_push = (req_q.cmd == mts_pkg::CmdPush);
  assign cnt_ge2 = (cnt_q >= CW'(2));
  assign cnt_m2  = cnt_q - CW'(2);

  assign v         = req_q.value;
  assign v_x       = {{2{v[DW-1]}}, v};
  assign min_x     = {{2{min_q[DW-1]}}, min_q};
  assign twice_v   = {v[DW-1], v, 1'b0};
  assign twice_min = {min_q[DW-1], min_q, 1'b0};

  // A push below the minimum stores 2*value - min, which lies below the new minimum.
  assign push_low = (v < min_q);
  assign enc_push = (empty || !push_low) ? v_x : (twice_v - min_x);

  // An entry below the minimum marks where the minimum changed.
  assign top_low = (top_enc_q < min_x);
  assign top_dec = top_low ? min_q : top_enc_q[DW-1:0];
  assign restore = twice_min - top_enc_q;

  assign mem_we = ctrl_i.exec && is_push && !full;
  assign mem_re = ctrl_i.exec && !is_push && cnt_ge2;

  mts_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (enc_push),
    .re_i    (mem_re),
    .raddr_i (cnt_m2[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    min_d = min_q;
    if (ctrl_i.exec) begin
      if (is_push) begin
        if (!full) begin
          cnt_d = cnt_q + CW'(1);
          if (empty || push_low) begin
            min_d = v;
          end
        end
      end else if (!empty) begin
        cnt_d = cnt_q - CW'(1);
        if (top_low) begin
          min_d = restore[DW-1:0];
        end
      end
    end
  end

  always_comb begin
    rsp_d.status       = st_q;
    rsp_d.popped_value = popped_q;
    rsp_d.top_value    = empty ? '0 : top_dec;
    rsp_d.min_value    = empty ? '0 : min_q;
    rsp_d.entry_count  = cnt_x[mts_pkg::CountWidth-1:0];
    rsp_d.is_empty     = empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= mts_pkg::CapReset;
      cnt_q       <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      min_q <= min_d;
      if (ctrl_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      req_q <= in_req_i;
    end
    if (ctrl_i.exec) begin
      if (is_push) begin
        st_q     <= full ? mts_pkg::StFull : mts_pkg::StOk;
        popped_q <= '0;
        if (!full) begin
          top_enc_q <= enc_push;
        end
      end else if (empty) begin
        st_q     <= mts_pkg::StEmpty;
        popped_q <= '0;
      end else begin
        st_q     <= mts_pkg::StOk;
        popped_q <= top_dec;
      end
    end
    if (ctrl_i.load_top) begin
      top_enc_q <= mem_rdata;
    end
    if (ctrl_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign status_o.refill   = !is_push && cnt_ge2;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_rsp_o         = rsp_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds memory depth");

  a_min_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> top_dec >= min_q)
    else $error("running minimum above the decoded top");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.status != mts_pkg::StOk |-> rsp_q.popped_value == '0)
    else $error("rejected request reports a popped value");
`endif

endmodule

// ===== src/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack controller
// Sequences one request at a time: accept, execute, optional top refill from
// memory, and hand-off to the output register.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mts_pkg::dp_status_t status_i,
  output mts_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DONE
  } state_e;

  state_e state_q;
  logic   in_stall_q;
  logic   accept;

  assign accept = in_valid_i && !in_stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_stall_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q    <= S_EXEC;
            in_stall_q <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q <= status_i.refill ? S_LOAD : S_DONE;
        end
        S_LOAD: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (status_i.out_free) begin
            state_q    <= S_IDLE;
            in_stall_q <= 1'b0;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_stall_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o      = in_stall_q;
  assign cmd_o.accept    = accept;
  assign cmd_o.exec      = (state_q == S_EXEC);
  assign cmd_o.load_top  = (state_q == S_LOAD);
  assign cmd_o.finish    = (state_q == S_DONE) && status_i.out_free;

`ifndef SYNTHESIS
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> status_i.out_free)
    else $error("result loaded into a busy output register");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o)
    else $error("input open while a request is in flight");

  a_load_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> $past(state_q) == S_EXEC)
    else $error("top refill outside a pop");
`endif

endmodule

// ===== verif/mts_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack scoreboard
// Keeps its own copy of the stack, the running minimum and the capacity,
// works out the response for every accepted request and compares the
// responses that the block delivers, in order, field by field.
// ----------------------------------------------------------------------------
package mts_scoreboard_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int StackDepth = 128;

  class min_stack_scoreboard;

    logic signed [EntryWidth-1:0] entries [StackDepth];
    int unsigned                  depth;
    logic signed [DataWidth-1:0]  cur_min;
    logic [CapWidth-1:0]          capacity;
    rsp_t                         expected_rsp_q [$];

    int unsigned errors;
    int unsigned rsp_checked;
    int unsigned full_rejects;
    int unsigned empty_rejects;
    int unsigned encoded_pushes;
    int unsigned peak_depth;

    function new();
      depth          = 0;
      cur_min        = '0;
      capacity       = CapReset;
      errors         = 0;
      rsp_checked    = 0;
      full_rejects   = 0;
      empty_rejects  = 0;
      encoded_pushes = 0;
      peak_depth     = 0;
    endfunction

    function void set_capacity(logic [CapWidth-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction

    // Applies one accepted request to the shadow stack and queues the
    // response the block has to produce for it.
    function void note_request(req_t req);
      rsp_t                         rsp;
      int unsigned                  limit;
      logic signed [EntryWidth-1:0] val_e;
      logic signed [EntryWidth-1:0] min_e;
      logic signed [EntryWidth-1:0] top_e;
      logic signed [EntryWidth-1:0] rebuilt;
      rsp    = '0;
      rsp.status = StOk;
      limit  = (capacity < StackDepth) ? capacity : StackDepth;
      val_e  = {{2{req.value[DataWidth-1]}}, req.value};
      min_e  = {{2{cur_min[DataWidth-1]}}, cur_min};
      if (req.cmd == CmdPush) begin
        if (depth >= limit) begin
          rsp.status = StFull;
          full_rejects++;
        end else begin
          if (depth == 0) begin
            entries[0] = val_e;
            cur_min    = req.value;
          end else if (val_e >= min_e) begin
            entries[depth] = val_e;
          end else begin
            // A new minimum is stored as twice the value minus the old minimum.
            entries[depth] = (val_e <<< 1) - min_e;
            cur_min        = req.value;
            encoded_pushes++;
          end
          depth++;
          if (depth > peak_depth) peak_depth = depth;
        end
      end else begin
        if (depth == 0) begin
          rsp.status = StEmpty;
          empty_rejects++;
        end else begin
          top_e = entries[depth-1];
          if (top_e >= min_e) begin
            rsp.popped_value = top_e[DataWidth-1:0];
          end else begin
            rsp.popped_value = cur_min;
            rebuilt          = (min_e <<< 1) - top_e;
            cur_min          = rebuilt[DataWidth-1:0];
          end
          depth--;
        end
      end
      if (depth > 0) begin
        min_e         = {{2{cur_min[DataWidth-1]}}, cur_min};
        top_e         = entries[depth-1];
        rsp.top_value = (top_e < min_e) ? cur_min : top_e[DataWidth-1:0];
        rsp.min_value = cur_min;
      end
      rsp.entry_count = depth[CountWidth-1:0];
      rsp.is_empty    = (depth == 0);
      expected_rsp_q.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(rsp_t act);
      rsp_t exp_rsp;
      if (expected_rsp_q.size() == 0) begin
        $error("response with no request outstanding: %p", act);
        errors++;
        return;
      end
      exp_rsp = expected_rsp_q.pop_front();
      rsp_checked++;
      compare_field("status", 32'(exp_rsp.status), 32'(act.status));
      compare_field("popped_value", exp_rsp.popped_value, act.popped_value);
      compare_field("top_value", exp_rsp.top_value, act.top_value);
      compare_field("min_value", exp_rsp.min_value, act.min_value);
      compare_field("entry_count", 32'(exp_rsp.entry_count), 32'(act.entry_count));
      compare_field("is_empty", 32'(exp_rsp.is_empty), 32'(act.is_empty));
    endfunction

  endclass

endpackage

// ===== verif/tb_min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack testbench
// Drives push and pop requests into the stack under several capacity
// settings, with random idle cycles on both channels, a long receiver
// hold-off and a full drain pause, and checks every response against a
// shadow stack kept by the scoreboard.
// ----------------------------------------------------------------------------
module tb_min_tracking_stack;

  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;
  import mts_scoreboard_pkg::*;

  localparam int NumPhases      = 9;
  localparam int PhaseItems     = 185;
  localparam int ShortItems     = 40;
  localparam int HoldOffCycles  = 300;
  // Settling time after every response has come back, to cover the tail.
  localparam int DrainCycles    = 8;
  // The longest quiet stretch is the receiver hold-off; allow it many times.
  localparam int WatchdogLimit  = 3000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CapWidth-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  req_t                in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rsp_t                out_rsp_o;

  min_stack_scoreboard stack_sb;

  // Idle chances in percent per cycle for the sender and the receiver.
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  // Raised by the main sequence; the receiver clears it and holds off.
  logic        hold_off_req;
  int unsigned requests_sent;
  int unsigned cap_writes;

  min_tracking_stack dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Values lean toward the extremes and a narrow band around zero, so that
  // pushes equal to the running minimum and new minima both come up often.
  function automatic logic [DataWidth-1:0] random_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($signed($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Offers one request after a random number of idle cycles and holds it
  // steady until the block accepts it.
  task automatic send_request(input req_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    do @(posedge clk_i); while (in_stall_o);
    stack_sb.note_request(req);
    requests_sent++;
  endtask

  task automatic push_value(input logic [DataWidth-1:0] value);
    req_t req;
    req.cmd   = CmdPush;
    req.value = value;
    send_request(req);
  endtask

  task automatic pop_entry();
    req_t req;
    req.cmd   = CmdPop;
    req.value = $urandom;
    send_request(req);
  endtask

  // Stops offering requests and waits until every response has come back,
  // then lets the block settle before it returns.
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (stack_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // The capacity register is only written while nothing is in flight.
  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    stack_sb.set_capacity(cap);
    cap_writes++;
  endtask

  // Random requests in segments of varying push bias. A fill phase starts
  // with a long push-heavy segment so that the stack reaches its limit.
  task automatic run_phase(input int unsigned n_items, input bit fill, input bit mid_drain);
    int unsigned seg_left;
    int unsigned push_pct;
    req_t        req;
    seg_left = fill ? 160 : 0;
    push_pct = 97;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 10);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      seg_left--;
      req.cmd   = ($urandom_range(99) < push_pct) ? CmdPush : CmdPop;
      req.value = random_value();
      send_request(req);
      // Once, the sender stops halfway until every response is back.
      if (mid_drain && i == n_items / 2) wait_drain();
    end
  endtask

  // The receiver stalls at random, except during the hold-off, which it
  // times itself while the sender keeps offering requests.
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i  = 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else begin
        out_stall_i = ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Every response the receiver takes is checked against the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stack_sb.check_response(out_rsp_o);
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL min_tracking_stack");
    $finish;
  end

  initial begin : main_seq
    logic [CapWidth-1:0] phase_cap [NumPhases];
    stack_sb      = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    tx_idle_pct   = 21;
    rx_stall_pct  = 21;
    hold_off_req  = 1'b0;
    requests_sent = 0;
    cap_writes    = 0;
    phase_cap     = '{8'd128, 8'd1, 8'd255, 8'd2, 8'd128, 8'd37, 8'd0, 8'd100, 8'd128};

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset capacity: pop on an empty stack, the word
    // extremes, a new minimum, a push equal to the minimum, and pops that
    // rebuild earlier minima until the stack is empty again.
    pop_entry();
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_value(32'd5);
    push_value(32'h8000_0000);
    push_value(32'h7FFF_FFFF);
    repeat (6) pop_entry();
    push_value(32'd10);
    push_value(32'd3);
    push_value(32'd3);
    push_value(-32'sd7);
    push_value(-32'sd8);
    repeat (5) pop_entry();

    // A small capacity rejects the third push as full.
    write_capacity(8'd2);
    push_value(32'd1);
    push_value(-32'sd1);
    push_value(32'd4);
    pop_entry();
    pop_entry();

    // A capacity of zero rejects every push.
    write_capacity(8'd0);
    push_value(32'd9);
    pop_entry();

    for (int p = 0; p < NumPhases; p++) begin
      write_capacity(phase_cap[p]);
      // Phase 4 is the long stretch in which neither side idles.
      tx_idle_pct  = (p == 4) ? 0 : 21;
      rx_stall_pct = (p == 4) ? 0 : 21;
      // In phase 2 the receiver holds off so the block backs up.
      if (p == 2) hold_off_req = 1'b1;
      run_phase((phase_cap[p] == 8'd0) ? ShortItems : PhaseItems,
                (p == 0 || p == 2 || p == 4), (p == 5));
    end

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests and %0d responses over %0d capacity settings.",
             requests_sent, stack_sb.rsp_checked, cap_writes);
    $display("Full rejects %0d, empty rejects %0d, new minima %0d, peak depth %0d.",
             stack_sb.full_rejects, stack_sb.empty_rejects, stack_sb.encoded_pushes,
             stack_sb.peak_depth);
    if (stack_sb.errors == 0 && stack_sb.pending() == 0) begin
      $display("PASS min_tracking_stack");
    end else begin
      $display("FAIL min_tracking_stack");
    end
    $finish;
  end

endmodule
